// ===== rtl/core/tstc_pkg.sv =====
`default_nettype none

package tstc_pkg;

    localparam int unsigned TS_W    = 64;
    localparam int unsigned STEP_W  = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned ITER_W  = $clog2(TS_W);

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(64'd50000000 / 64'd3);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [TS_W-1:0]   dividend;
        logic [STEP_W-1:0] divisor;
    } t_div_ctl;

    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] quotient;
        logic [STEP_W-1:0]  remainder;
    } t_div_sts;

endpackage

`default_nettype wire

// ===== rtl/core/tstc_div.sv =====
`default_nettype none

module tstc_div (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire tstc_pkg::t_div_ctl i_ctl,
    output tstc_pkg::t_div_sts     o_sts
);

    logic [tstc_pkg::TS_W-1:0]   r_quo;
    logic [tstc_pkg::STEP_W-1:0] r_rem;
    logic [tstc_pkg::STEP_W-1:0] r_div;
    logic [tstc_pkg::ITER_W-1:0] r_iter;
    logic                        r_busy;
    logic                        r_done;

    logic [tstc_pkg::STEP_W:0]   shifted;
    logic [tstc_pkg::STEP_W+1:0] diff;
    logic                        fits;

    // One restoring step: bring down the next dividend bit and subtract if it fits.
    assign shifted = {r_rem, r_quo[tstc_pkg::TS_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_div};
    assign fits    = ~diff[tstc_pkg::STEP_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_iter == {tstc_pkg::ITER_W{1'b1}})) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo  <= i_ctl.dividend;
            r_rem  <= '0;
            r_div  <= i_ctl.divisor;
            r_iter <= '0;
        end else if (r_busy) begin
            r_quo  <= {r_quo[tstc_pkg::TS_W-2:0], fits};
            r_rem  <= fits ? diff[tstc_pkg::STEP_W-1:0] : shifted[tstc_pkg::STEP_W-1:0];
            r_iter <= r_iter + 1'b1;
        end
    end

    assign o_sts.done      = r_done;
    assign o_sts.quotient  = r_quo[tstc_pkg::COUNT_W-1:0];
    assign o_sts.remainder = r_rem;

endmodule

`default_nettype wire

// ===== rtl/core/timestamp_to_tick_converter.sv =====
// Timestamp to tick converter.
// Input channel: i_in_valid / o_in_ready carry one 64-bit timestamp reading per transfer.
// Output channel: o_out_valid / i_out_ready carry the 32-bit tick count after that reading.
// The step register (timestamp units per tick) resets to 16666666; the user must write it
// via i_cfg_wr_en and i_cfg_wr_data only while the block is idle; no logic enforces it.
// The first reading after reset sets the anchor and returns a count of 1.
// Every later reading subtracts the anchor, becomes the new anchor, adds the kept
// remainder and divides by the step in a restoring divider that retires one
// quotient bit per cycle, 64 iterations in all.
// With a zero step no division runs and the unchanged count is returned.
// One reading is processed at a time: a new reading is taken only once the count
// of the previous one has moved to the output register.
// A finished count waits in an output register; the next reading is taken while it
// waits, but its own result is held in the sequencer until the receiver takes the
// previous one.
// Reset is synchronous and active low: it restores the step, forgets the anchor
// and drops any pending result.
`default_nettype none

module timestamp_to_tick_converter (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_wr_en,
    input  wire  [tstc_pkg::STEP_W-1:0]        i_cfg_wr_data,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire  [tstc_pkg::TS_W-1:0]          i_timestamp,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [tstc_pkg::COUNT_W-1:0]       o_tick_count
);

    tstc_pkg::t_state r_state;
    tstc_pkg::t_state n_state;

    logic [tstc_pkg::STEP_W-1:0]  r_step;
    logic                         r_started;
    logic [tstc_pkg::TS_W-1:0]    r_anchor;
    logic [tstc_pkg::TS_W-1:0]    r_elapsed;
    logic [tstc_pkg::STEP_W-1:0]  r_rem;
    logic [tstc_pkg::COUNT_W-1:0] r_count;
    logic                         r_out_valid;
    logic [tstc_pkg::COUNT_W-1:0] r_tick_count;

    tstc_pkg::t_div_ctl div_ctl;
    tstc_pkg::t_div_sts div_sts;

    logic in_xfer;
    logic out_free;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    tstc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .o_sts   (div_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tstc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        div_ctl.start    = 1'b0;
        div_ctl.dividend = r_elapsed + {{(tstc_pkg::TS_W-tstc_pkg::STEP_W){1'b0}}, r_rem};
        div_ctl.divisor  = r_step;
        unique case (r_state)
            tstc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = r_started ? tstc_pkg::ST_ADD : tstc_pkg::ST_DONE;
                end
            end
            tstc_pkg::ST_ADD: begin
                if (r_step == '0) begin
                    n_state = tstc_pkg::ST_DONE;
                end else begin
                    div_ctl.start = 1'b1;
                    n_state       = tstc_pkg::ST_DIV;
                end
            end
            tstc_pkg::ST_DIV: begin
                if (div_sts.done) begin
                    n_state = tstc_pkg::ST_DONE;
                end
            end
            tstc_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = tstc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tstc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= tstc_pkg::STEP_RESET;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_step <= i_cfg_wr_data;
            end
            if (in_xfer) begin
                r_started <= 1'b1;
            end
            if (r_state == tstc_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_anchor  <= i_timestamp;
            r_elapsed <= i_timestamp - r_anchor;
            if (!r_started) begin
                r_rem   <= '0;
                r_count <= {{(tstc_pkg::COUNT_W-1){1'b0}}, 1'b1};
            end
        end
        if (r_state == tstc_pkg::ST_DIV && div_sts.done) begin
            r_rem   <= div_sts.remainder;
            r_count <= r_count + div_sts.quotient;
        end
        if (r_state == tstc_pkg::ST_DONE && out_free) begin
            r_tick_count <= r_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_tick_count = r_tick_count;

endmodule

`default_nettype wire

// ===== rtl/core/tstc_checker.sv =====
`default_nettype none

module tstc_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_in_valid,
    input wire                               o_in_ready,
    input wire                               o_out_valid,
    input wire                               i_out_ready,
    input wire [tstc_pkg::COUNT_W-1:0]       o_tick_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_tick_count)))
        else $error("Output transfer dropped or changed while stalled.");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Input ready stayed high after an input transfer.");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !$rose(o_out_valid))
        else $error("Result appeared one cycle after an input transfer.");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("Block not idle after reset.");

endmodule

bind timestamp_to_tick_converter tstc_checker u_tstc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_tick_count (o_tick_count)
);

`default_nettype wire
